FILE: hdl/dtq_pkg.sv
package dtq_pkg;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned LINK_W = $clog2(SLOTS + 1);
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOTS);
  localparam logic [31:0] MIN_DELAY_RESET = 32'd1000;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [2:0] ST_STARTED   = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_QUEUED = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_NOTHING   = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] delay;
    logic [6:0]  handle;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  handle_out;
    logic        armed;
    logic [31:0] next_deadline;
    logic        last;
  } out_item_t;

endpackage

FILE: hdl/dtq_if.sv
interface dtq_in_if;
  logic valid;
  logic ready;
  dtq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/dtq_out_if.sv
interface dtq_out_if;
  logic valid;
  logic ready;
  dtq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/deadline_timer_queue.sv
// deadline_timer_queue: 64-slot one-shot timer queue kept as a linked list
// sorted by (wrap flag, deadline).
// channels: cmd (sink) carries command, delay, handle, now; rsp (source)
// carries status, handle_out, armed, next_deadline, last. a transaction on
// either side happens when valid and ready are high at a rising clk edge.
// the user must write min_delay through cfg_we / cfg_data only while the
// block is idle; the block does not enforce it. one item is processed at a
// time; cmd.ready is low until the item is done and its last result has
// left the output register. the list is walked through registered table
// reads, each slot visited being read before it is checked:
//   start: free-slot scan, list walk, then link and format
//   cancel: walk along the list up to the slot of the handle
//   tick: wrap clearing walk over all queued slots when now is below
//     prev_now, then a check of each head. a tick emits one transaction
//     per expired timer and last marks the final one; with none expired
//     it emits a single nothing result.
// when the receiver stalls the result waits in the output register and the
// expiry walk pauses; no state is lost.
// rst (synchronous) empties the queue, clears prev_now and restores
// min_delay to 1000; no clearing pass is needed since busy bits are flops.
module deadline_timer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  dtq_in_if.sink      cmd,
  dtq_out_if.source   rsp
);

  localparam int unsigned SW = dtq_pkg::SLOT_W;
  localparam int unsigned LW = dtq_pkg::LINK_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_INS_RD, S_INS_WALK, S_INS_SET, S_INS_PREV, S_CAN_RD,
    S_CAN_WALK, S_WRAP_RD, S_WRAP_WALK, S_EXP_RD, S_EXP_CHK, S_OUT_RD, S_OUT
  } state_t;

  // slot tables, one registered read port each, addressed by cur
  logic [32:0]   dl_mem   [dtq_pkg::SLOTS];   // {wrap flag, deadline}
  logic [LW-1:0] link_mem [dtq_pkg::SLOTS];
  logic [32:0]   dl_rd;
  logic [LW-1:0] link_rd;
  logic          dl_we;
  logic          ln_we;
  logic [SW-1:0] dl_wa;
  logic [SW-1:0] ln_wa;
  logic [32:0]   dl_wd;
  logic [LW-1:0] ln_wd;
  logic [dtq_pkg::SLOTS-1:0] slot_busy;

  state_t state;
  logic [LW-1:0] queue_head;
  logic [31:0]   prev_now;
  logic [31:0]   min_delay;
  dtq_pkg::in_item_t item;
  logic [LW-1:0] cur, prev, slot;   // walk pointers and new slot
  logic [31:0]   new_dl;
  logic          new_wr;
  logic          exp_any;           // an expired slot waits to be reported
  logic [2:0]    res_status;
  logic [6:0]    res_handle;
  logic          out_valid;
  dtq_pkg::out_item_t out_data;

  logic [32:0] sum;
  logic [31:0] eff_delay;
  logic        key_after;
  logic        cur_hit;
  logic        due;
  logic        out_free;
  logic        out_load;

  assign eff_delay = (item.delay < min_delay) ? min_delay : item.delay;
  assign sum = {1'b0, item.now} + {1'b0, eff_delay};
  // insert walk compare: new key strictly after the key of the slot just read
  assign key_after = (new_wr != dl_rd[32]) ? new_wr : (new_dl > dl_rd[31:0]);
  assign cur_hit = (7'(cur) + 7'd1 == item.handle);
  // slot at cur is present, not wrapped and at or below now
  assign due = (cur != dtq_pkg::NIL_LINK) && !dl_rd[32] &&
               (dl_rd[31:0] <= item.now);
  assign out_free = !out_valid || rsp.ready;
  assign out_load = (state == S_OUT) ||
                    ((state == S_EXP_CHK) && out_free && (exp_any || !due));

  assign cmd.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // result fields from the head pointer and its deadline
  function automatic dtq_pkg::out_item_t mk(logic [2:0] st, logic [6:0] h,
                                            logic [LW-1:0] hd, logic [31:0] dl,
                                            logic lst);
    dtq_pkg::out_item_t r;
    r.status = st;
    r.handle_out = h;
    r.armed = (hd != dtq_pkg::NIL_LINK);
    r.next_deadline = (hd != dtq_pkg::NIL_LINK) ? dl : 32'd0;
    r.last = lst;
    return r;
  endfunction

  // table write port selection
  always_comb begin
    dl_we = 1'b0;
    dl_wa = slot[SW-1:0];
    dl_wd = {new_wr, new_dl};
    ln_we = 1'b0;
    ln_wa = slot[SW-1:0];
    ln_wd = cur;
    case (state)
      S_INS_SET: begin
        dl_we = 1'b1;
        ln_we = 1'b1;
      end
      S_INS_PREV: begin
        ln_we = 1'b1;
        ln_wa = prev[SW-1:0];
        ln_wd = slot;
      end
      S_CAN_WALK: begin
        if (cur_hit && prev != dtq_pkg::NIL_LINK) begin
          ln_we = 1'b1;
          ln_wa = prev[SW-1:0];
          ln_wd = link_rd;
        end
      end
      S_WRAP_WALK: begin
        dl_we = 1'b1;
        dl_wa = cur[SW-1:0];
        dl_wd = {1'b0, dl_rd[31:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    if (ln_we) link_mem[ln_wa] <= ln_wd;
    dl_rd <= dl_mem[cur[SW-1:0]];
    link_rd <= link_mem[cur[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      queue_head <= dtq_pkg::NIL_LINK;
      prev_now <= 32'd0;
      min_delay <= dtq_pkg::MIN_DELAY_RESET;
      slot_busy <= '0;
      out_valid <= 1'b0;
      exp_any <= 1'b0;
    end else begin
      if (cfg_we) min_delay <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            item <= cmd.data;
            case (cmd.data.command)
              dtq_pkg::CMD_START: begin
                slot <= '0;
                state <= S_SCAN;
              end
              dtq_pkg::CMD_CANCEL: begin
                cur <= queue_head;
                prev <= dtq_pkg::NIL_LINK;
                state <= S_CAN_RD;
              end
              dtq_pkg::CMD_TICK: begin
                cur <= queue_head;
                exp_any <= 1'b0;
                state <= (cmd.data.now < prev_now) ? S_WRAP_RD : S_EXP_RD;
                prev_now <= cmd.data.now;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // lowest free slot, one per cycle
        S_SCAN: begin
          if (slot == dtq_pkg::NIL_LINK) begin
            res_status <= dtq_pkg::ST_FULL;
            res_handle <= 7'd0;
            cur <= queue_head;
            state <= S_OUT_RD;
          end else if (!slot_busy[slot[SW-1:0]]) begin
            new_dl <= sum[31:0];
            new_wr <= sum[32];
            slot_busy[slot[SW-1:0]] <= 1'b1;
            cur <= queue_head;
            prev <= dtq_pkg::NIL_LINK;
            state <= S_INS_RD;
          end else begin
            slot <= slot + LW'(1);
          end
        end
        S_INS_RD: begin
          state <= (cur == dtq_pkg::NIL_LINK) ? S_INS_SET : S_INS_WALK;
        end
        S_INS_WALK: begin
          if (key_after) begin
            prev <= cur;
            cur <= link_rd;
            state <= S_INS_RD;
          end else begin
            state <= S_INS_SET;
          end
        end
        // new slot written here; a predecessor, if any, is relinked next cycle
        S_INS_SET: begin
          res_status <= dtq_pkg::ST_STARTED;
          res_handle <= 7'(slot) + 7'd1;
          if (prev == dtq_pkg::NIL_LINK) begin
            queue_head <= slot;
            cur <= slot;
            state <= S_OUT_RD;
          end else begin
            cur <= queue_head;
            state <= S_INS_PREV;
          end
        end
        S_INS_PREV: state <= S_OUT;
        S_CAN_RD: begin
          if (cur == dtq_pkg::NIL_LINK) begin
            res_status <= dtq_pkg::ST_NOT_QUEUED;
            res_handle <= 7'd0;
            cur <= queue_head;
            state <= S_OUT_RD;
          end else begin
            state <= S_CAN_WALK;
          end
        end
        S_CAN_WALK: begin
          if (cur_hit) begin
            slot_busy[cur[SW-1:0]] <= 1'b0;
            res_status <= dtq_pkg::ST_CANCELLED;
            res_handle <= 7'd0;
            if (prev == dtq_pkg::NIL_LINK) begin
              queue_head <= link_rd;
              cur <= link_rd;
            end else begin
              cur <= queue_head;
            end
            state <= S_OUT_RD;
          end else begin
            prev <= cur;
            cur <= link_rd;
            state <= S_CAN_RD;
          end
        end
        // clear wrap flags along the list
        S_WRAP_RD: begin
          if (cur == dtq_pkg::NIL_LINK) begin
            cur <= queue_head;
            state <= S_EXP_RD;
          end else begin
            state <= S_WRAP_WALK;
          end
        end
        S_WRAP_WALK: begin
          cur <= link_rd;
          state <= S_WRAP_RD;
        end
        S_EXP_RD: state <= S_EXP_CHK;
        // the pending expiry is reported once the next head is known
        S_EXP_CHK: begin
          if (out_free) begin
            if (exp_any) begin
              out_data <= mk(dtq_pkg::ST_EXPIRED, 7'(slot) + 7'd1, cur,
                             dl_rd[31:0], !due);
            end else if (!due) begin
              out_data <= mk(dtq_pkg::ST_NOTHING, 7'd0, cur, dl_rd[31:0],
                             1'b1);
            end
            if (due) begin
              slot <= cur;
              slot_busy[cur[SW-1:0]] <= 1'b0;
              queue_head <= link_rd;
              cur <= link_rd;
              exp_any <= 1'b1;
              state <= S_EXP_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT_RD: state <= S_OUT;
        S_OUT: begin
          out_data <= mk(res_status, res_handle, cur, dl_rd[31:0], 1'b1);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
